// ===== rtl/imuac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuac_pkg
// Shared types, constants and register indexes of the IMU attitude conditioner.
// ----------------------------------------------------------------------------
package imuac_pkg;

    // Sample width of angles and rates
    localparam int SAMPLE_WIDTH       = 16;
    // Width of a gamma register as stored
    localparam int GAMMA_REG_WIDTH    = 16;
    // Default fraction width of the smoothing weight
    localparam int GAMMA_BITS_DEFAULT = 16;

    // Angles are radians times 8192
    localparam int PI_FIX     = 25736;
    localparam int TWO_PI_FIX = 51472;

    // Configuration port
    localparam int APB_ADDR_WIDTH  = 5;
    localparam int APB_DATA_WIDTH  = 32;
    localparam int REG_INDEX_WIDTH = 3;

    localparam logic [REG_INDEX_WIDTH-1:0] REG_PITCH_INVERT    = 3'd0;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_PITCH_OFFSET    = 3'd1;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_ROLL_INVERT     = 3'd2;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_ROLL_OFFSET     = 3'd3;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_SWAP_ROLL_PITCH = 3'd4;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_YAW_RATE_GAMMA  = 3'd5;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_ROLL_RATE_GAMMA = 3'd6;
    localparam logic [REG_INDEX_WIDTH-1:0] REG_PITCH_RATE_GAMMA = 3'd7;

    // Event kinds
    localparam logic KIND_ROTATION = 1'b0;
    localparam logic KIND_GYRO     = 1'b1;

    typedef struct packed {
        logic                            kind;
        logic signed [SAMPLE_WIDTH-1:0]  raw_roll;
        logic signed [SAMPLE_WIDTH-1:0]  raw_pitch;
        logic signed [SAMPLE_WIDTH-1:0]  raw_yaw;
        logic signed [SAMPLE_WIDTH-1:0]  gyro_x;
        logic signed [SAMPLE_WIDTH-1:0]  gyro_y;
        logic signed [SAMPLE_WIDTH-1:0]  gyro_z;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0]  roll_out;
        logic signed [SAMPLE_WIDTH-1:0]  pitch_out;
        logic signed [SAMPLE_WIDTH-1:0]  yaw_out;
        logic signed [SAMPLE_WIDTH-1:0]  roll_rate_out;
        logic signed [SAMPLE_WIDTH-1:0]  pitch_rate_out;
        logic signed [SAMPLE_WIDTH-1:0]  yaw_rate_out;
    } result_t;

    typedef struct packed {
        logic                              pitch_invert;
        logic signed [SAMPLE_WIDTH-1:0]    pitch_offset;
        logic                              roll_invert;
        logic signed [SAMPLE_WIDTH-1:0]    roll_offset;
        logic                              swap_roll_pitch;
        logic [GAMMA_REG_WIDTH-1:0]        yaw_rate_gamma;
        logic [GAMMA_REG_WIDTH-1:0]        roll_rate_gamma;
        logic [GAMMA_REG_WIDTH-1:0]        pitch_rate_gamma;
    } cfg_t;

endpackage

// ===== rtl/imu_attitude_conditioner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_attitude_conditioner_core
// Conditions rotation events (invert, offset, wrap, swap) and smooths gyro
// rates with a per-axis exponential moving average.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                           | Transfer when
//  ---------+-----------------------------------+-----------------------------
//  sample   | sample_valid, sample_ready, sample| sample_valid && sample_ready
//  result   | result_valid, result_ready, result| result_valid && result_ready
//  config   | psel, penable, pwrite, paddr,     | psel && penable && pwrite
//           | pwdata, prdata, pready            | (pready tied high)
//
//  A transferred sample is captured in the input register and passes through
//  one 17x17 multiply per axis into the result register; one event is taken
//  per cycle while result_ready does not stall the result register.
//  The result register doubles as the held state, so each event sees the
//  rates left by the one before it. Reset clears the configuration and all
//  six held values to zero. A stalled result holds the input register, which
//  still takes one more sample before sample_ready drops.
// ----------------------------------------------------------------------------
module imu_attitude_conditioner_core
#(
    parameter int GAMMA_BITS = imuac_pkg::GAMMA_BITS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   sample_valid,
    output logic                                   sample_ready,
    input  imuac_pkg::sample_t                     sample,

    output logic                                   result_valid,
    input  logic                                   result_ready,
    output imuac_pkg::result_t                     result,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [imuac_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [imuac_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [imuac_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                   pready
);

    localparam int SW = imuac_pkg::SAMPLE_WIDTH;

    imuac_pkg::cfg_t      cfg;

    // Input stage
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    imuac_pkg::sample_t   s1_item_reg;
    imuac_pkg::sample_t   s1_item_next;

    // Result stage, also the held state
    logic                 result_valid_reg;
    logic                 result_valid_next;
    imuac_pkg::result_t   result_reg;
    imuac_pkg::result_t   result_next;

    logic                 sample_xfer;
    logic                 advance;

    logic signed [SW-1:0] ang_roll;
    logic signed [SW-1:0] ang_pitch;
    logic signed [SW-1:0] ang_yaw;
    logic signed [SW-1:0] roll_gyro;
    logic signed [SW-1:0] pitch_gyro;
    logic signed [SW-1:0] roll_rate_new;
    logic signed [SW-1:0] pitch_rate_new;
    logic signed [SW-1:0] yaw_rate_new;

    imuac_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    imuac_angle_path u_angle
    (
        .item  (s1_item_reg),
        .cfg   (cfg),
        .roll  (ang_roll),
        .pitch (ang_pitch),
        .yaw   (ang_yaw)
    );

    // Swap changes which gyro axis feeds roll and pitch rates
    assign roll_gyro  = cfg.swap_roll_pitch ? s1_item_reg.gyro_x : s1_item_reg.gyro_y;
    assign pitch_gyro = cfg.swap_roll_pitch ? s1_item_reg.gyro_y : s1_item_reg.gyro_x;

    imuac_rate_axis #(.GAMMA_BITS(GAMMA_BITS)) u_roll_rate
    (
        .held     (result_reg.roll_rate_out),
        .gyro     (roll_gyro),
        .gamma    (cfg.roll_rate_gamma),
        .smoothed (roll_rate_new)
    );

    imuac_rate_axis #(.GAMMA_BITS(GAMMA_BITS)) u_pitch_rate
    (
        .held     (result_reg.pitch_rate_out),
        .gyro     (pitch_gyro),
        .gamma    (cfg.pitch_rate_gamma),
        .smoothed (pitch_rate_new)
    );

    imuac_rate_axis #(.GAMMA_BITS(GAMMA_BITS)) u_yaw_rate
    (
        .held     (result_reg.yaw_rate_out),
        .gyro     (s1_item_reg.gyro_z),
        .gamma    (cfg.yaw_rate_gamma),
        .smoothed (yaw_rate_new)
    );

    // Advance the input stage whenever the result register is free or draining
    assign advance      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || advance;
    assign sample_xfer  = sample_valid && sample_ready;

    always_comb
    begin
        s1_item_next  = s1_item_reg;
        s1_valid_next = s1_valid_reg;
        if (sample_xfer)
        begin
            s1_item_next  = sample;
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
            if (s1_item_reg.kind == imuac_pkg::KIND_ROTATION)
            begin
                // Rotation event: replace angles, keep rates
                result_next.roll_out  = cfg.swap_roll_pitch ? ang_pitch : ang_roll;
                result_next.pitch_out = cfg.swap_roll_pitch ? ang_roll  : ang_pitch;
                result_next.yaw_out   = ang_yaw;
            end
            else
            begin
                // Gyro event: smooth rates, keep angles
                result_next.roll_rate_out  = roll_rate_new;
                result_next.pitch_rate_out = pitch_rate_new;
                result_next.yaw_rate_out   = yaw_rate_new;
            end
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // Payload only, no reset needed
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/imuac_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuac_cfg_regs
// APB register file holding the conditioner's configuration.
// ----------------------------------------------------------------------------
module imuac_cfg_regs
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [imuac_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [imuac_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [imuac_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                   pready,
    output imuac_pkg::cfg_t                        cfg
);

    localparam int SW = imuac_pkg::SAMPLE_WIDTH;
    localparam int GR = imuac_pkg::GAMMA_REG_WIDTH;
    localparam int DW = imuac_pkg::APB_DATA_WIDTH;

    imuac_pkg::cfg_t                            cfg_reg;
    imuac_pkg::cfg_t                            cfg_next;
    logic [imuac_pkg::REG_INDEX_WIDTH-1:0]      reg_index;
    logic                                       write_en;

    assign reg_index = paddr[imuac_pkg::APB_ADDR_WIDTH-1:2];
    assign write_en  = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            case (reg_index)
                imuac_pkg::REG_PITCH_INVERT:     cfg_next.pitch_invert     = pwdata[0];
                imuac_pkg::REG_PITCH_OFFSET:     cfg_next.pitch_offset     = pwdata[SW-1:0];
                imuac_pkg::REG_ROLL_INVERT:      cfg_next.roll_invert      = pwdata[0];
                imuac_pkg::REG_ROLL_OFFSET:      cfg_next.roll_offset      = pwdata[SW-1:0];
                imuac_pkg::REG_SWAP_ROLL_PITCH:  cfg_next.swap_roll_pitch  = pwdata[0];
                imuac_pkg::REG_YAW_RATE_GAMMA:   cfg_next.yaw_rate_gamma   = pwdata[GR-1:0];
                imuac_pkg::REG_ROLL_RATE_GAMMA:  cfg_next.roll_rate_gamma  = pwdata[GR-1:0];
                imuac_pkg::REG_PITCH_RATE_GAMMA: cfg_next.pitch_rate_gamma = pwdata[GR-1:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            imuac_pkg::REG_PITCH_INVERT:     prdata = DW'(cfg_reg.pitch_invert);
            imuac_pkg::REG_PITCH_OFFSET:     prdata = DW'($unsigned(cfg_reg.pitch_offset));
            imuac_pkg::REG_ROLL_INVERT:      prdata = DW'(cfg_reg.roll_invert);
            imuac_pkg::REG_ROLL_OFFSET:      prdata = DW'($unsigned(cfg_reg.roll_offset));
            imuac_pkg::REG_SWAP_ROLL_PITCH:  prdata = DW'(cfg_reg.swap_roll_pitch);
            imuac_pkg::REG_YAW_RATE_GAMMA:   prdata = DW'(cfg_reg.yaw_rate_gamma);
            imuac_pkg::REG_ROLL_RATE_GAMMA:  prdata = DW'(cfg_reg.roll_rate_gamma);
            imuac_pkg::REG_PITCH_RATE_GAMMA: prdata = DW'(cfg_reg.pitch_rate_gamma);
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/imuac_angle_path.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuac_angle_path
// Invert and offset roll and pitch, and wrap all three angles of a rotation event.
// ----------------------------------------------------------------------------
module imuac_angle_path
(
    input  imuac_pkg::sample_t                          item,
    input  imuac_pkg::cfg_t                             cfg,
    output logic signed [imuac_pkg::SAMPLE_WIDTH-1:0]   roll,
    output logic signed [imuac_pkg::SAMPLE_WIDTH-1:0]   pitch,
    output logic signed [imuac_pkg::SAMPLE_WIDTH-1:0]   yaw
);

    localparam int SW = imuac_pkg::SAMPLE_WIDTH;
    // Two guard bits: one for negating the most negative value, one for the offset
    localparam int AW = SW + 2;
    localparam logic signed [AW-1:0] PI_A     = AW'(imuac_pkg::PI_FIX);
    localparam logic signed [AW-1:0] TWO_PI_A = AW'(imuac_pkg::TWO_PI_FIX);

    function automatic logic signed [AW-1:0] wrap_once(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] w;
        if (a > PI_A)
            w = a - TWO_PI_A;
        else if (a < -PI_A)
            w = a + TWO_PI_A;
        else
            w = a;
        return w;
    endfunction

    logic signed [AW-1:0] roll_ext;
    logic signed [AW-1:0] pitch_ext;
    logic signed [AW-1:0] roll_sum;
    logic signed [AW-1:0] pitch_sum;
    logic signed [AW-1:0] roll_wrap;
    logic signed [AW-1:0] pitch_wrap;
    logic signed [AW-1:0] yaw_wrap;

    always_comb
    begin
        roll_ext   = cfg.roll_invert  ? -AW'(item.raw_roll)  : AW'(item.raw_roll);
        pitch_ext  = cfg.pitch_invert ? -AW'(item.raw_pitch) : AW'(item.raw_pitch);
        roll_sum   = roll_ext  + AW'(cfg.roll_offset);
        pitch_sum  = pitch_ext + AW'(cfg.pitch_offset);
        roll_wrap  = wrap_once(roll_sum);
        pitch_wrap = wrap_once(pitch_sum);
        yaw_wrap   = wrap_once(AW'(item.raw_yaw));
    end

    assign roll  = roll_wrap[SW-1:0];
    assign pitch = pitch_wrap[SW-1:0];
    assign yaw   = yaw_wrap[SW-1:0];

endmodule

// ===== rtl/imuac_rate_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imuac_rate_axis
// One axis of the rate smoother: gyro + floor((held - gyro) * gamma / 2^GAMMA_BITS).
// ----------------------------------------------------------------------------
module imuac_rate_axis
#(
    parameter int GAMMA_BITS = imuac_pkg::GAMMA_BITS_DEFAULT
)
(
    input  logic signed [imuac_pkg::SAMPLE_WIDTH-1:0]   held,
    input  logic signed [imuac_pkg::SAMPLE_WIDTH-1:0]   gyro,
    input  logic [imuac_pkg::GAMMA_REG_WIDTH-1:0]       gamma,
    output logic signed [imuac_pkg::SAMPLE_WIDTH-1:0]   smoothed
);

    localparam int SW = imuac_pkg::SAMPLE_WIDTH;
    // Only the low GAMMA_BITS bits of the stored weight take part
    localparam int GW = (GAMMA_BITS < imuac_pkg::GAMMA_REG_WIDTH) ?
                        GAMMA_BITS : imuac_pkg::GAMMA_REG_WIDTH;
    localparam int DW = SW + 1;
    localparam int PW = DW + GW + 1;

    logic signed [DW-1:0] diff;
    logic signed [GW:0]   gamma_s;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] step;
    logic signed [DW-1:0] sum;

    always_comb
    begin
        diff    = DW'(held) - DW'(gyro);
        gamma_s = $signed({1'b0, gamma[GW-1:0]});
        prod    = PW'(diff) * PW'(gamma_s);
        // Arithmetic shift gives the floor of the quotient for either sign
        step    = prod >>> GAMMA_BITS;
        sum     = DW'(gyro) + step[DW-1:0];
    end

    assign smoothed = sum[SW-1:0];

endmodule

// ===== bench/tb_imu_attitude_conditioner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_attitude_conditioner_core
// Self-checking bench for the IMU attitude conditioner. Rotation and gyro
// events are pushed through the sample channel under random valid/ready
// gaps. A tracker class keeps its own copy of the registers and held values,
// predicts the six outputs of every event, and checks each result transfer
// in order. The configuration is reprogrammed over APB between phases,
// each time once the result stream has drained.
// ----------------------------------------------------------------------------

class attitude_tracker;

    // shadow copy of the register file
    bit                  pitch_invert;
    logic signed [15:0]  pitch_offset;
    bit                  roll_invert;
    logic signed [15:0]  roll_offset;
    bit                  swap_roll_pitch;
    logic [15:0]         yaw_gamma;
    logic [15:0]         roll_gamma;
    logic [15:0]         pitch_gamma;

    // held attitude and rates, as the block should hold them
    logic signed [15:0]  held_roll;
    logic signed [15:0]  held_pitch;
    logic signed [15:0]  held_yaw;
    logic signed [15:0]  held_roll_rate;
    logic signed [15:0]  held_pitch_rate;
    logic signed [15:0]  held_yaw_rate;

    imuac_pkg::result_t  awaited_attitudes[$];
    int                  mismatches;

    function new();
        pitch_invert    = 1'b0;
        pitch_offset    = '0;
        roll_invert     = 1'b0;
        roll_offset     = '0;
        swap_roll_pitch = 1'b0;
        yaw_gamma       = '0;
        roll_gamma      = '0;
        pitch_gamma     = '0;
        held_roll       = '0;
        held_pitch      = '0;
        held_yaw        = '0;
        held_roll_rate  = '0;
        held_pitch_rate = '0;
        held_yaw_rate   = '0;
        mismatches      = 0;
    endfunction

    function void write_reg(logic [imuac_pkg::REG_INDEX_WIDTH-1:0] index,
                            logic [31:0] value);
        case (index)
            imuac_pkg::REG_PITCH_INVERT:     pitch_invert    = value[0];
            imuac_pkg::REG_PITCH_OFFSET:     pitch_offset    = value[15:0];
            imuac_pkg::REG_ROLL_INVERT:      roll_invert     = value[0];
            imuac_pkg::REG_ROLL_OFFSET:      roll_offset     = value[15:0];
            imuac_pkg::REG_SWAP_ROLL_PITCH:  swap_roll_pitch = value[0];
            imuac_pkg::REG_YAW_RATE_GAMMA:   yaw_gamma       = value[15:0];
            imuac_pkg::REG_ROLL_RATE_GAMMA:  roll_gamma      = value[15:0];
            imuac_pkg::REG_PITCH_RATE_GAMMA: pitch_gamma     = value[15:0];
            default: ;
        endcase
    endfunction

    // one wrap into +/- pi
    function int wrap_angle(int angle);
        if (angle > imuac_pkg::PI_FIX)
            return angle - imuac_pkg::TWO_PI_FIX;
        if (angle < -imuac_pkg::PI_FIX)
            return angle + imuac_pkg::TWO_PI_FIX;
        return angle;
    endfunction

    // target + floor((held - target) * gamma / 2^GAMMA_BITS)
    function logic signed [15:0] ema_step(logic signed [15:0] held,
                                          logic signed [15:0] target,
                                          logic [15:0] gamma);
        longint gamma_mask;
        longint weighted;
        gamma_mask = (longint'(1) << imuac_pkg::GAMMA_BITS_DEFAULT) - 1;
        weighted = (longint'(held) - longint'(target)) * (longint'(gamma) & gamma_mask);
        return 16'(longint'(target) + (weighted >>> imuac_pkg::GAMMA_BITS_DEFAULT));
    endfunction

    function void log_event(imuac_pkg::sample_t ev);
        imuac_pkg::result_t outcome;
        int roll;
        int pitch;
        int yaw;
        if (ev.kind == imuac_pkg::KIND_ROTATION)
        begin
            roll  = int'(ev.raw_roll);
            pitch = int'(ev.raw_pitch);
            yaw   = int'(ev.raw_yaw);
            // negating -32768 gives +32768 here, before the offset
            if (pitch_invert)
                pitch = -pitch;
            pitch = wrap_angle(pitch + int'(pitch_offset));
            if (roll_invert)
                roll = -roll;
            roll = wrap_angle(roll + int'(roll_offset));
            yaw = wrap_angle(yaw);
            if (swap_roll_pitch)
            begin
                held_roll  = 16'(pitch);
                held_pitch = 16'(roll);
            end
            else
            begin
                held_roll  = 16'(roll);
                held_pitch = 16'(pitch);
            end
            held_yaw = 16'(yaw);
        end
        else
        begin
            held_yaw_rate = ema_step(held_yaw_rate, ev.gyro_z, yaw_gamma);
            if (swap_roll_pitch)
            begin
                held_roll_rate  = ema_step(held_roll_rate, ev.gyro_x, roll_gamma);
                held_pitch_rate = ema_step(held_pitch_rate, ev.gyro_y, pitch_gamma);
            end
            else
            begin
                held_roll_rate  = ema_step(held_roll_rate, ev.gyro_y, roll_gamma);
                held_pitch_rate = ema_step(held_pitch_rate, ev.gyro_x, pitch_gamma);
            end
        end
        outcome.roll_out       = held_roll;
        outcome.pitch_out      = held_pitch;
        outcome.yaw_out        = held_yaw;
        outcome.roll_rate_out  = held_roll_rate;
        outcome.pitch_rate_out = held_pitch_rate;
        outcome.yaw_rate_out   = held_yaw_rate;
        awaited_attitudes.push_back(outcome);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, field,
                         $signed(want), $signed(got));
        end
    endfunction

    function void check_attitude(imuac_pkg::result_t got);
        imuac_pkg::result_t want;
        if (awaited_attitudes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result transfer with no event pending", $realtime);
            return;
        end
        want = awaited_attitudes.pop_front();
        compare_field("roll_out", want.roll_out, got.roll_out);
        compare_field("pitch_out", want.pitch_out, got.pitch_out);
        compare_field("yaw_out", want.yaw_out, got.yaw_out);
        compare_field("roll_rate_out", want.roll_rate_out, got.roll_rate_out);
        compare_field("pitch_rate_out", want.pitch_rate_out, got.pitch_rate_out);
        compare_field("yaw_rate_out", want.yaw_rate_out, got.yaw_rate_out);
    endfunction

endclass

module tb_imu_attitude_conditioner_core;

    import imuac_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 125;
    // leave margin after the last result before touching registers
    localparam int DRAIN_CYCLES    = 8;
    // longest legal quiet stretch is a sender gap plus a receiver stall plus
    // the pipeline, well under the limit
    localparam int WATCHDOG_LIMIT  = 5000;

    logic                       clk;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_ready;
    sample_t                    sample;
    logic                       result_valid;
    logic                       result_ready;
    result_t                    result;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_WIDTH-1:0]  paddr;
    logic [APB_DATA_WIDTH-1:0]  pwdata;
    logic [APB_DATA_WIDTH-1:0]  prdata;
    logic                       pready;

    // per-phase switches for random gaps on each side
    bit                         sample_idle_on;
    bit                         result_idle_on;
    int                         quiet_cycles = 0;

    attitude_tracker            tracker;

    imu_attitude_conditioner_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: count cycles with no transfer on any port; give up at the limit.
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready)
            || (psel && penable && pwrite))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Angle draw: mostly in +/- pi, sometimes the full 16-bit span, and the
    // wrap thresholds and field extremes now and then.
    function automatic int draw_angle();
        case ($urandom_range(0, 19))
            0:       return -32768;
            1:       return 32767;
            2:       return PI_FIX;
            3:       return -PI_FIX;
            4:       return PI_FIX + 1;
            5:       return -PI_FIX - 1;
            6, 7:    return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 2 * PI_FIX)) - PI_FIX;
        endcase
    endfunction

    function automatic int draw_rate();
        case ($urandom_range(0, 15))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int draw_gamma();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 65535;
            2:       return 1;
            3:       return 32768;
            default: return int'($urandom_range(0, 65535));
        endcase
    endfunction

    // Fill the fields of the other kind with noise; the block must ignore them.
    function automatic sample_t rotation_event(int roll, int pitch, int yaw);
        sample_t ev;
        ev.kind      = KIND_ROTATION;
        ev.raw_roll  = 16'(roll);
        ev.raw_pitch = 16'(pitch);
        ev.raw_yaw   = 16'(yaw);
        ev.gyro_x    = 16'($urandom);
        ev.gyro_y    = 16'($urandom);
        ev.gyro_z    = 16'($urandom);
        return ev;
    endfunction

    function automatic sample_t gyro_event(int gx, int gy, int gz);
        sample_t ev;
        ev.kind      = KIND_GYRO;
        ev.raw_roll  = 16'($urandom);
        ev.raw_pitch = 16'($urandom);
        ev.raw_yaw   = 16'($urandom);
        ev.gyro_x    = 16'(gx);
        ev.gyro_y    = 16'(gy);
        ev.gyro_z    = 16'(gz);
        return ev;
    endfunction

    // Hold valid and payload until the transfer; drop valid only for a gap.
    task automatic send_event(input sample_t ev);
        int gap;
        gap = sample_idle_on ? int'($urandom_range(0, 9)) : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= ev;
        do @(posedge clk); while (!sample_ready);
        tracker.log_event(ev);
    endtask

    // Setup then access phase; the register takes the data at the access edge.
    // Bits above the register width are noise, so scramble them now and then.
    task automatic apb_write(input logic [REG_INDEX_WIDTH-1:0] index,
                             input logic [31:0] value);
        logic [31:0] keep;
        logic [31:0] data;
        keep = (index == REG_PITCH_INVERT || index == REG_ROLL_INVERT
                || index == REG_SWAP_ROLL_PITCH) ? 32'h1 : 32'hFFFF;
        data = value & keep;
        if ($urandom_range(0, 3) == 0)
            data = data | ($urandom & ~keep);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tracker.write_reg(index, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_config(input bit p_inv, input int p_off, input bit r_inv,
                                  input int r_off, input bit swap, input int y_gamma,
                                  input int r_gamma, input int p_gamma);
        apb_write(REG_PITCH_INVERT, 32'(p_inv));
        apb_write(REG_PITCH_OFFSET, 32'(p_off));
        apb_write(REG_ROLL_INVERT, 32'(r_inv));
        apb_write(REG_ROLL_OFFSET, 32'(r_off));
        apb_write(REG_SWAP_ROLL_PITCH, 32'(swap));
        apb_write(REG_YAW_RATE_GAMMA, 32'(y_gamma));
        apb_write(REG_ROLL_RATE_GAMMA, 32'(r_gamma));
        apb_write(REG_PITCH_RATE_GAMMA, 32'(p_gamma));
    endtask

    // Drop valid after the last transfer, wait for every predicted result,
    // then let the pipeline settle.
    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (tracker.awaited_attitudes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: stall a random number of cycles, then hold ready until a
    // transfer and check it against the oldest prediction.
    initial
    begin
        int stall;
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = result_idle_on ? int'($urandom_range(0, 9)) : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            tracker.check_attitude(result);
        end
    end

    initial
    begin
        int gyro_share;
        tracker = new();
        sample_idle_on = 1'b1;
        result_idle_on = 1'b1;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: no inversion, no offset, no swap, zero gamma.
        // Hit the wrap thresholds and the 16-bit extremes; zero gamma makes
        // the held rates jump straight to the gyro axes.
        send_event(rotation_event(0, 0, 0));
        send_event(rotation_event(PI_FIX, -PI_FIX, PI_FIX));
        send_event(rotation_event(PI_FIX + 1, -PI_FIX - 1, 32767));
        send_event(rotation_event(-32768, 32767, -32768));
        send_event(gyro_event(32767, -32768, 12345));
        send_event(gyro_event(-32768, 32767, -1));
        wait_drained();

        // Both inversions, offsets at the field extremes, swap on, heavy gamma.
        // Inverting -32768 must give +32768 before the offset.
        program_config(1'b1, 32767, 1'b1, -32768, 1'b1, 65535, 65535, 32768);
        send_event(rotation_event(-32768, -32768, 100));
        send_event(rotation_event(32767, 32767, -PI_FIX - 1));
        send_event(rotation_event(0, 0, 0));
        send_event(gyro_event(32767, -32768, 32767));
        send_event(gyro_event(-32768, 32767, -32768));
        send_event(gyro_event(0, 0, 0));
        send_event(gyro_event(1, -1, 1));
        wait_drained();

        // Opposite offset extremes, swap off, light, mid and heavy gamma.
        program_config(1'b0, -32768, 1'b0, 32767, 1'b0, 1, 32768, 65535);
        send_event(rotation_event(32767, -32768, -PI_FIX));
        send_event(rotation_event(-32768, 32767, PI_FIX + 1));
        send_event(gyro_event(-32768, 32767, 32767));
        send_event(gyro_event(100, -100, -32768));
        send_event(gyro_event(-5, 5, 7));
        wait_drained();

        // Random phases: fresh registers, a random mix of the two kinds, and
        // per-side idling that is either on or off for the whole phase.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_config(1'($urandom), draw_angle(), 1'($urandom), draw_angle(),
                           1'($urandom), draw_gamma(), draw_gamma(), draw_gamma());
            sample_idle_on = ($urandom_range(0, 3) != 0);
            result_idle_on = ($urandom_range(0, 3) != 0);
            gyro_share     = int'($urandom_range(0, 100));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (int'($urandom_range(0, 99)) < gyro_share)
                    send_event(gyro_event(draw_rate(), draw_rate(), draw_rate()));
                else
                    send_event(rotation_event(draw_angle(), draw_angle(), draw_angle()));
            end
            wait_drained();
        end

        sample_valid <= 1'b0;
        wait_drained();
        if (tracker.mismatches == 0 && tracker.awaited_attitudes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== imu_attitude_conditioner_core.f =====
rtl/imuac_pkg.sv
rtl/imuac_cfg_regs.sv
rtl/imuac_angle_path.sv
rtl/imuac_rate_axis.sv
rtl/imu_attitude_conditioner_core.sv
bench/tb_imu_attitude_conditioner_core.sv
